// File: src/obbsat_pkg.sv
// Shared constants for the oriented-box face-axis overlap test.
// No dependencies.
package obbsat_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SELF_CENTER     = 3'd0;
    localparam logic [2:0] REG_SELF_AXIS_U     = 3'd1;
    localparam logic [2:0] REG_SELF_AXIS_V     = 3'd2;
    localparam logic [2:0] REG_SELF_AXIS_W     = 3'd3;
    localparam logic [2:0] REG_SELF_HALF_SIZES = 3'd4;

    localparam int CFG_INDEX_WIDTH = 3;

endpackage

// File: src/obb_face_axis_overlap_test_top.sv
// Top level of the oriented-box face-axis overlap test: five-stage pipeline.
// Depends on obbsat_pkg.
//
// Holds one reference box in configuration registers and tests one streamed
// box per cycle against it on the six face axes. Stage 1 forms the component
// products of the nine axis pairs and the center offset. Stage 2 sums them
// into the rotation terms. Stage 3 rounds the rotation magnitudes and projects
// the offset. Stage 4 forms the extent products. Stage 5 sums the extents,
// compares and registers the flag. One item is taken per cycle while the output
// is not stalled; a stalled output holds all stages, with ready flowing back
// combinationally. The write data port is as wide as the widest packed register.
module obb_face_axis_overlap_test_top
    import obbsat_pkg::*;
#(
    parameter int COORD_WIDTH = 20,
    parameter int AXIS_WIDTH  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [((COORD_WIDTH > AXIS_WIDTH) ? 3*COORD_WIDTH : 3*AXIS_WIDTH)-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3*COORD_WIDTH-1:0]    other_center,
    input  logic [3*AXIS_WIDTH-1:0]     other_axis_u,
    input  logic [3*AXIS_WIDTH-1:0]     other_axis_v,
    input  logic [3*AXIS_WIDTH-1:0]     other_axis_w,
    input  logic [3*COORD_WIDTH-1:0]    other_half_sizes,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        overlap
);

    localparam int AF   = AXIS_WIDTH - 2;
    localparam int PW   = 2 * AXIS_WIDTH;          // axis product
    localparam int RW   = PW + 2;                  // dot of two axes
    localparam int MW   = RW - AF + 1;             // rounded magnitude + 1
    localparam int TW   = COORD_WIDTH + 1;         // center offset
    localparam int TPW  = TW + AXIS_WIDTH;         // offset times component
    localparam int TDW  = TPW + 2;                 // offset projection
    localparam int EW   = COORD_WIDTH + MW;        // extent product
    localparam int SW   = EW + 3;                  // comparison width
    localparam int NST  = 5;

    // Configuration registers
    logic [3*COORD_WIDTH-1:0] center_reg;
    logic [3*AXIS_WIDTH-1:0]  axis_reg [3];
    logic [3*COORD_WIDTH-1:0] half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= '0;
            axis_reg[0] <= (3*AXIS_WIDTH)'(1) << AF;
            axis_reg[1] <= (3*AXIS_WIDTH)'(1) << (AF + AXIS_WIDTH);
            axis_reg[2] <= (3*AXIS_WIDTH)'(1) << (AF + 2*AXIS_WIDTH);
            half_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SELF_CENTER:     center_reg  <= cfg_data[3*COORD_WIDTH-1:0];
                REG_SELF_AXIS_U:     axis_reg[0] <= cfg_data[3*AXIS_WIDTH-1:0];
                REG_SELF_AXIS_V:     axis_reg[1] <= cfg_data[3*AXIS_WIDTH-1:0];
                REG_SELF_AXIS_W:     axis_reg[2] <= cfg_data[3*AXIS_WIDTH-1:0];
                REG_SELF_HALF_SIZES: half_reg    <= cfg_data[3*COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: advance when the last stage is empty or drained
    logic [NST-1:0] valid_reg;
    logic           advance;

    assign advance  = !valid_reg[NST-1] || out_ready;
    assign in_ready = advance;
    assign out_valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[NST-2:0], in_valid};
    end

    // Unpack the input box
    logic signed [AXIS_WIDTH-1:0]  bax [3][3];
    logic signed [AXIS_WIDTH-1:0]  aax [3][3];
    logic signed [TW-1:0]          toff [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            bax[0][k] = other_axis_u[k*AXIS_WIDTH +: AXIS_WIDTH];
            bax[1][k] = other_axis_v[k*AXIS_WIDTH +: AXIS_WIDTH];
            bax[2][k] = other_axis_w[k*AXIS_WIDTH +: AXIS_WIDTH];
            for (int i = 0; i < 3; i++)
                aax[i][k] = axis_reg[i][k*AXIS_WIDTH +: AXIS_WIDTH];
            toff[k] = TW'($signed(other_center[k*COORD_WIDTH +: COORD_WIDTH]))
                    - TW'($signed(center_reg[k*COORD_WIDTH +: COORD_WIDTH]));
        end
    end

    // Stage 1: component products of every axis pair, center offset
    logic signed [PW-1:0]         s1_prod_reg [3][3][3];
    logic signed [TW-1:0]         s1_t_reg [3];
    logic signed [AXIS_WIDTH-1:0] s1_a_reg [3][3];
    logic signed [AXIS_WIDTH-1:0] s1_b_reg [3][3];
    logic [3*COORD_WIDTH-1:0]     s1_ha_reg, s1_hb_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        s1_prod_reg[i][j][k] <= PW'(aax[i][k]) * PW'(bax[j][k]);
            s1_t_reg  <= toff;
            s1_a_reg  <= aax;
            s1_b_reg  <= bax;
            s1_ha_reg <= half_reg;
            s1_hb_reg <= other_half_sizes;
        end
    end

    // Stage 2: rotation sums, offset-by-component products
    logic signed [RW-1:0]   s2_r_reg [3][3];
    logic signed [TPW-1:0]  s2_ta_reg [3][3];
    logic signed [TPW-1:0]  s2_tb_reg [3][3];
    logic [3*COORD_WIDTH-1:0] s2_ha_reg, s2_hb_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s2_r_reg[i][j] <= RW'(s1_prod_reg[i][j][0]) + RW'(s1_prod_reg[i][j][1])
                                    + RW'(s1_prod_reg[i][j][2]);
                    s2_ta_reg[i][j] <= TPW'(s1_t_reg[j]) * TPW'(s1_a_reg[i][j]);
                    s2_tb_reg[i][j] <= TPW'(s1_t_reg[j]) * TPW'(s1_b_reg[i][j]);
                end
            end
            s2_ha_reg <= s1_ha_reg;
            s2_hb_reg <= s1_hb_reg;
        end
    end

    // Stage 3: rounded rotation magnitudes plus epsilon, offset projections
    logic [MW-1:0]   s3_ar_reg [3][3];
    logic [TDW-1:0]  s3_la_reg [3];
    logic [TDW-1:0]  s3_lb_reg [3];
    logic [3*COORD_WIDTH-1:0] s3_ha_reg, s3_hb_reg;
    logic [RW-1:0]   rmag [3][3];
    logic [RW:0]     rrnd [3][3];
    logic signed [TDW-1:0] pa [3];
    logic signed [TDW-1:0] pb [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rmag[i][j] = s2_r_reg[i][j][RW-1] ? RW'(-s2_r_reg[i][j])
                                                  : RW'(s2_r_reg[i][j]);
                rrnd[i][j] = {1'b0, rmag[i][j]} + ((RW+1)'(1) << (AF - 1));
            end
            pa[i] = TDW'(s2_ta_reg[i][0]) + TDW'(s2_ta_reg[i][1]) + TDW'(s2_ta_reg[i][2]);
            pb[i] = TDW'(s2_tb_reg[i][0]) + TDW'(s2_tb_reg[i][1]) + TDW'(s2_tb_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    s3_ar_reg[i][j] <= MW'(rrnd[i][j] >> AF) + MW'(1);
                s3_la_reg[i] <= pa[i][TDW-1] ? TDW'(-pa[i]) : TDW'(pa[i]);
                s3_lb_reg[i] <= pb[i][TDW-1] ? TDW'(-pb[i]) : TDW'(pb[i]);
            end
            s3_ha_reg <= s2_ha_reg;
            s3_hb_reg <= s2_hb_reg;
        end
    end

    // Stage 4: extent products of half sizes and rotation magnitudes
    logic [EW-1:0]   s4_ea_reg [3][3];   // ha[i] * ar[i][j]
    logic [EW-1:0]   s4_eb_reg [3][3];   // hb[j] * ar[i][j]
    logic [TDW-1:0]  s4_la_reg [3];
    logic [TDW-1:0]  s4_lb_reg [3];
    logic [3*COORD_WIDTH-1:0] s4_ha_reg, s4_hb_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    s4_ea_reg[i][j] <= EW'(s3_ha_reg[i*COORD_WIDTH +: COORD_WIDTH])
                                     * EW'(s3_ar_reg[i][j]);
                    s4_eb_reg[i][j] <= EW'(s3_hb_reg[j*COORD_WIDTH +: COORD_WIDTH])
                                     * EW'(s3_ar_reg[i][j]);
                end
            s4_la_reg <= s3_la_reg;
            s4_lb_reg <= s3_lb_reg;
            s4_ha_reg <= s3_ha_reg;
            s4_hb_reg <= s3_hb_reg;
        end
    end

    // Stage 5: sum extents, compare on all six axes, register the flag
    logic [SW-1:0] lim_a [3];
    logic [SW-1:0] lim_b [3];
    logic          apart;
    logic          overlap_reg;

    always_comb
    begin
        apart = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lim_a[i] = (SW'(s4_ha_reg[i*COORD_WIDTH +: COORD_WIDTH]) << AF)
                     + SW'(s4_eb_reg[i][0]) + SW'(s4_eb_reg[i][1]) + SW'(s4_eb_reg[i][2]);
            lim_b[i] = (SW'(s4_hb_reg[i*COORD_WIDTH +: COORD_WIDTH]) << AF)
                     + SW'(s4_ea_reg[0][i]) + SW'(s4_ea_reg[1][i]) + SW'(s4_ea_reg[2][i]);
            if (SW'(s4_la_reg[i]) > lim_a[i] || SW'(s4_lb_reg[i]) > lim_b[i])
                apart = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            overlap_reg <= !apart;
    end

    assign overlap = overlap_reg;

    // A stalled result holds its value
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(overlap))
        else $error("result changed during stall");

    // Input is taken whenever the output side is free
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused while output empty");

    // An accepted item shows up at the output in an unstalled run
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready
        |=> out_valid)
        else $error("pipeline lost an item");

endmodule
